### rtl/core/dnn_pkg.sv
package dnn_pkg;

  // Name parser phase
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_STAR   = 3'd1,
    PH_LSTART = 3'd2,
    PH_LABEL  = 3'd3,
    PH_ERROR  = 3'd4
  } phase_e;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CASE_OFS  = 8'h20;  // 'a' - 'A'

  // One result beat
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       done_res;
    logic       status;
  } result_t;

  // Lowercased label character, or CH_NUL when the byte is not allowed in a label
  function automatic logic [7:0] label_char(input logic [7:0] c);
    logic [7:0] n;
    n = CH_NUL;
    if (c inside {[8'h41:8'h5A]}) begin
      n = c + CASE_OFS;
    end else if (c inside {[8'h61:8'h7A], [8'h30:8'h39], CH_HYPHEN}) begin
      n = c;
    end
    return n;
  endfunction

endpackage

### rtl/core/domain_name_normalizer.sv
// Each accepted byte's result beat is registered (in the skid register if stalled).
// One byte per cycle while in_stall_o is low; parser state updates per accepted byte.
// A two-entry output stage (result register plus skid register) keeps input
// acceptance free of the output stall path; in_stall_o rises only when both are full.
// Reset (rst_ni low, asynchronous): parser returns to start of name, lengths clear,
// output and skid registers empty.
module domain_name_normalizer #(
  parameter int MAX_LABEL = 63,
  parameter int MAX_NAME  = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       done_res_o,
  output logic       status_o
);

  localparam int LabelW = $clog2(MAX_LABEL + 1);
  localparam int TotalW = $clog2(MAX_NAME + 1);
  localparam logic [LabelW-1:0] LabelMax = LabelW'(MAX_LABEL);
  localparam logic [TotalW-1:0] TotalMax = TotalW'(MAX_NAME);

  dnn_pkg::phase_e    phase_q, phase_d;
  logic [LabelW-1:0]  lbl_cnt_q, lbl_cnt_d;
  logic [TotalW-1:0]  total_len_q, total_len_d;
  logic               prev_hyphen_q, prev_hyphen_d;

  dnn_pkg::result_t   res_d;
  dnn_pkg::result_t   out_q, skid_q;
  logic               out_valid_q, skid_valid_q;
  logic               in_accept, out_ready;
  logic [7:0]         lc;

  assign in_accept = in_valid_i && !skid_valid_q;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign lc        = dnn_pkg::label_char(ch_i);

  // Parse one byte: next state and result
  always_comb begin
    phase_d       = phase_q;
    lbl_cnt_d     = lbl_cnt_q;
    total_len_d   = total_len_q;
    prev_hyphen_d = prev_hyphen_q;
    res_d         = '0;
    if (ch_i == dnn_pkg::CH_NUL) begin
      res_d.done_res = 1'b1;
      case (phase_q)
        dnn_pkg::PH_STAR:  res_d.status = 1'b0;
        dnn_pkg::PH_LABEL: res_d.status = prev_hyphen_q;
        default:           res_d.status = 1'b1;
      endcase
      phase_d       = dnn_pkg::PH_START;
      lbl_cnt_d     = '0;
      total_len_d   = '0;
      prev_hyphen_d = 1'b0;
    end else if (!(phase_q inside {dnn_pkg::PH_START, dnn_pkg::PH_STAR,
                                   dnn_pkg::PH_LSTART, dnn_pkg::PH_LABEL})) begin
      phase_d = dnn_pkg::PH_ERROR;
    end else if (total_len_q >= TotalMax) begin
      phase_d = dnn_pkg::PH_ERROR;
    end else if (phase_q == dnn_pkg::PH_START && ch_i == dnn_pkg::CH_STAR) begin
      res_d.out_char   = dnn_pkg::CH_STAR;
      res_d.char_valid = 1'b1;
      total_len_d      = total_len_q + 1'b1;
      phase_d          = dnn_pkg::PH_STAR;
    end else if (phase_q == dnn_pkg::PH_STAR) begin
      if (ch_i == dnn_pkg::CH_DOT) begin
        res_d.out_char   = dnn_pkg::CH_DOT;
        res_d.char_valid = 1'b1;
        total_len_d      = total_len_q + 1'b1;
        phase_d          = dnn_pkg::PH_LSTART;
      end else begin
        phase_d = dnn_pkg::PH_ERROR;
      end
    end else if (ch_i == dnn_pkg::CH_DOT) begin
      if (phase_q == dnn_pkg::PH_LABEL && !prev_hyphen_q) begin
        res_d.out_char   = dnn_pkg::CH_DOT;
        res_d.char_valid = 1'b1;
        total_len_d      = total_len_q + 1'b1;
        lbl_cnt_d        = '0;
        prev_hyphen_d    = 1'b0;
        phase_d          = dnn_pkg::PH_LSTART;
      end else begin
        phase_d = dnn_pkg::PH_ERROR;
      end
    end else if (lc == dnn_pkg::CH_NUL || lbl_cnt_q >= LabelMax ||
                 (phase_q != dnn_pkg::PH_LABEL && lc == dnn_pkg::CH_HYPHEN)) begin
      phase_d = dnn_pkg::PH_ERROR;
    end else begin
      res_d.out_char   = lc;
      res_d.char_valid = 1'b1;
      total_len_d      = total_len_q + 1'b1;
      lbl_cnt_d        = lbl_cnt_q + 1'b1;
      prev_hyphen_d    = (lc == dnn_pkg::CH_HYPHEN);
      phase_d          = dnn_pkg::PH_LABEL;
    end
  end

  // Advance parser state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= dnn_pkg::PH_START;
      lbl_cnt_q     <= '0;
      total_len_q   <= '0;
      prev_hyphen_q <= 1'b0;
    end else if (in_accept) begin
      phase_q       <= phase_d;
      lbl_cnt_q     <= lbl_cnt_d;
      total_len_q   <= total_len_d;
      prev_hyphen_q <= prev_hyphen_d;
    end
  end

  // Output and skid occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q  <= skid_valid_q || in_accept;
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output and skid payload: drain skid first, else load fresh result
  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (in_accept) begin
      skid_q <= res_d;
    end
  end

  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_q.out_char;
  assign char_valid_o = out_q.char_valid;
  assign done_res_o   = out_q.done_res;
  assign status_o     = out_q.status;

endmodule

### rtl/core/dnn_checker.sv
module dnn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] ch_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_char_o,
  input logic       char_valid_o,
  input logic       done_res_o,
  input logic       status_o
);

  // Terminator beat carries no byte
  a_done_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !char_valid_o && out_char_o == 8'h00)
    else $error("terminator beat carries a byte");

  // Status only meaningful with done
  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> !status_o)
    else $error("status set without done");

  // Dropped bytes read as zero
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_valid_o |-> out_char_o == 8'h00)
    else $error("dropped byte not zero");

  // Emitted bytes are never uppercase
  a_lowercase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_valid_o |-> !(out_char_o >= 8'h41 && out_char_o <= 8'h5A))
    else $error("uppercase byte emitted");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o) &&
      $stable(char_valid_o) && $stable(done_res_o) && $stable(status_o))
    else $error("stalled result beat changed");

endmodule

bind domain_name_normalizer dnn_checker u_dnn_checker (.*);
